/* rtl/char_stream_tokenizer_top_defines.svh */
// Assertion helpers for the tokenizer. Both sample on the rising edge of clk_i
// and are off while rst_ni is low.
`ifndef CHAR_STREAM_TOKENIZER_TOP_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cst: check failed");

// Next-cycle implication.
`define CST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cst: check failed");

`endif

/* rtl/cst_pkg.sv */
`default_nettype none

package cst_pkg;

  // Field widths.
  localparam int unsigned LineBits   = 20;
  localparam int unsigned ColumnBits = 16;
  localparam int unsigned LenBits    = 16;

  // Result queue depth; each source byte adds at most two tokens.
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrBits    = $clog2(FifoDepth);
  localparam int unsigned CountBits  = $clog2(FifoDepth + 1);

  // Token kinds.
  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_LITERAL = 3'd2,
    KIND_OPER    = 3'd3,
    KIND_PUNCT   = 3'd4,
    KIND_UNKNOWN = 3'd5,
    KIND_EOF     = 3'd6
  } token_kind_e;

  // Scanner mode, one-hot.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } scan_mode_e;

  // Keyword matcher progress through "if" and "else".
  localparam logic [2:0] KwStart = 3'd0;
  localparam logic [2:0] KwI     = 3'd1;
  localparam logic [2:0] KwIf    = 3'd2;
  localparam logic [2:0] KwE     = 3'd3;
  localparam logic [2:0] KwEl    = 3'd4;
  localparam logic [2:0] KwEls   = 3'd5;
  localparam logic [2:0] KwElse  = 3'd6;
  localparam logic [2:0] KwNone  = 3'd7;

  // Keyword indexes.
  localparam logic KwIdxIf   = 1'b0;
  localparam logic KwIdxElse = 1'b1;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    token_kind_e           token_kind;
    logic                  keyword_index;
    logic [7:0]            symbol;
    logic [LineBits-1:0]   start_line;
    logic [ColumnBits-1:0] start_column;
    logic [LenBits-1:0]    token_length;
    logic                  last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/char_stream_tokenizer_top.sv */
// Streaming lexical tokenizer.
// Source bytes arrive on the input channel (in_valid_i / in_ready_o, payload
// in_data_i), one byte per word, with an end-of-text flag; a zero byte also
// ends the text. Tokens leave on the output channel (out_valid_o /
// out_ready_i, payload out_data_o), one token per word, in source order.
// A byte is scanned in the cycle it is accepted: the scanner state and
// counters update at that edge and the tokens it causes (zero, one or two)
// are written into a four-entry result queue at that edge. The queue drains
// one token per cycle while out_ready_i is high.
// Throughput is one byte per cycle while out_ready_i is high and each
// byte yields at most one token; a byte that closes a word and also forms
// a token of its own adds two, so such bytes go at the output's drain rate.
// in_ready_o is high while the queue has room for two tokens; when the
// receiver stalls the queue fills and input stops, with nothing lost.
// End of text flushes any open word, emits the end-of-file token marked
// last_of_run and returns the scanner to line 1, column 1.
// Reset (rst_ni low) empties the queue and sets the scanner to that start
// state at once; no setup is needed afterwards.
`default_nettype none

module char_stream_tokenizer_top
  import cst_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_item_t out_data_o
);

  `include "char_stream_tokenizer_top_defines.svh"

  localparam logic [LineBits-1:0]   LineMax   = '1;
  localparam logic [ColumnBits-1:0] ColumnMax = '1;
  localparam logic [LenBits-1:0]    LenMax    = '1;

  // Scanner state.
  scan_mode_e            mode_q, mode_d;
  logic [LineBits-1:0]   line_q, line_d;
  logic [ColumnBits-1:0] col_q, col_d;
  logic [ColumnBits-1:0] start_col_q, start_col_d;
  logic [LenBits-1:0]    len_q, len_d;
  logic [2:0]            kw_q, kw_d;

  // Result queue.
  out_item_t             fifo_q [FifoDepth];
  logic [PtrBits-1:0]    wptr_q, rptr_q;
  logic [CountBits-1:0]  count_q, count_d;

  logic                  in_accept, out_accept;
  logic [7:0]            ch;
  logic                  eot;
  logic                  flush, has_tok;
  out_item_t             flush_tok, tok, res0, res1;
  logic [ColumnBits-1:0] col_bump;
  logic [1:0]            push_n;
  logic [PtrBits-1:0]    wptr_next;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [2:0] next_match(input logic [2:0] m, input logic [7:0] c);
    logic [2:0] r;
    r = KwNone;
    if      ((m == KwStart) && (c == "i")) r = KwI;
    else if ((m == KwI)     && (c == "f")) r = KwIf;
    else if ((m == KwStart) && (c == "e")) r = KwE;
    else if ((m == KwE)     && (c == "l")) r = KwEl;
    else if ((m == KwEl)    && (c == "s")) r = KwEls;
    else if ((m == KwEls)   && (c == "e")) r = KwElse;
    return r;
  endfunction

  assign in_ready_o  = (count_q <= CountBits'(FifoDepth - 2));
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_accept  = out_valid_o && out_ready_i;
  assign out_data_o  = fifo_q[rptr_q];

  assign ch       = in_data_i.character;
  assign eot      = in_data_i.end_of_text || (ch == 8'h00);
  assign col_bump = (col_q != ColumnMax) ? col_q + ColumnBits'(1) : col_q;

  // Token for the open word, if it is closed by this byte.
  always_comb begin
    flush_tok               = '0;
    flush_tok.start_line    = line_q;
    flush_tok.start_column  = start_col_q;
    flush_tok.token_length  = len_q;
    unique case (mode_q)
      MODE_IDENT: begin
        if (kw_q == KwIf) begin
          flush_tok.token_kind    = KIND_KEYWORD;
          flush_tok.keyword_index = KwIdxIf;
        end else if (kw_q == KwElse) begin
          flush_tok.token_kind    = KIND_KEYWORD;
          flush_tok.keyword_index = KwIdxElse;
        end else begin
          flush_tok.token_kind    = KIND_IDENT;
        end
      end
      MODE_NUMBER: flush_tok.token_kind = KIND_LITERAL;
      default:     flush_tok.token_kind = KIND_UNKNOWN;
    endcase
  end

  // Scan one byte: next state and the byte's own token.
  always_comb begin
    mode_d       = mode_q;
    line_d       = line_q;
    col_d        = col_q;
    start_col_d  = start_col_q;
    len_d        = len_q;
    kw_d         = kw_q;
    flush        = 1'b0;
    has_tok      = 1'b0;
    tok              = '0;
    tok.token_kind   = KIND_UNKNOWN;
    tok.start_line   = line_q;
    tok.start_column = col_q;
    if (in_accept) begin
      if (eot) begin
        flush          = (mode_q != MODE_IDLE);
        has_tok        = 1'b1;
        tok.token_kind = KIND_EOF;
        mode_d         = MODE_IDLE;
        line_d         = LineBits'(1);
        col_d          = ColumnBits'(1);
        start_col_d    = ColumnBits'(1);
        len_d          = '0;
        kw_d           = KwStart;
      end else if ((mode_q == MODE_IDENT) && (is_alpha(ch) || is_digit(ch) || ch == "_")) begin
        len_d = (len_q != LenMax) ? len_q + LenBits'(1) : len_q;
        kw_d  = next_match(kw_q, ch);
        col_d = col_bump;
      end else if ((mode_q == MODE_NUMBER) && is_digit(ch)) begin
        len_d = (len_q != LenMax) ? len_q + LenBits'(1) : len_q;
        col_d = col_bump;
      end else begin
        flush  = (mode_q != MODE_IDLE);
        mode_d = MODE_IDLE;
        if (is_space(ch)) begin
          if (ch == 8'h0A) begin
            line_d = (line_q != LineMax) ? line_q + LineBits'(1) : line_q;
            col_d  = ColumnBits'(1);
          end else begin
            col_d = col_bump;
          end
        end else if (is_alpha(ch) || ch == "_") begin
          mode_d      = MODE_IDENT;
          start_col_d = col_q;
          len_d       = LenBits'(1);
          kw_d        = next_match(KwStart, ch);
          col_d       = col_bump;
        end else if (is_digit(ch)) begin
          mode_d      = MODE_NUMBER;
          start_col_d = col_q;
          len_d       = LenBits'(1);
          kw_d        = KwNone;
          col_d       = col_bump;
        end else if (ch == "+" || ch == "-" || ch == "*" || ch == "/" || ch == "=") begin
          has_tok          = 1'b1;
          tok.token_kind   = KIND_OPER;
          tok.symbol       = ch;
          tok.token_length = LenBits'(1);
          col_d            = col_bump;
        end else if (ch == ";" || ch == "," || ch == "(" || ch == ")") begin
          has_tok          = 1'b1;
          tok.token_kind   = KIND_PUNCT;
          tok.symbol       = ch;
          tok.token_length = LenBits'(1);
          col_d            = col_bump;
        end else begin
          has_tok = 1'b1;
          col_d   = col_bump;
        end
      end
    end
  end

  // Order the tokens of this byte and mark the final one.
  always_comb begin
    res0             = flush ? flush_tok : tok;
    res0.last_of_run = !(flush && has_tok);
    res1             = tok;
    res1.last_of_run = 1'b1;
    push_n           = {1'b0, flush} + {1'b0, has_tok};
    wptr_next        = wptr_q + PtrBits'(1);
    count_d          = count_q + CountBits'(push_n) - CountBits'(out_accept);
  end

  // Scanner registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      line_q      <= LineBits'(1);
      col_q       <= ColumnBits'(1);
      start_col_q <= ColumnBits'(1);
      len_q       <= '0;
      kw_q        <= KwStart;
    end else begin
      mode_q      <= mode_d;
      line_q      <= line_d;
      col_q       <= col_d;
      start_col_q <= start_col_d;
      len_q       <= len_d;
      kw_q        <= kw_d;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PtrBits'(push_n);
      if (out_accept) begin
        rptr_q <= rptr_q + PtrBits'(1);
      end
      count_q <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wptr_next] <= res1;
    end
  end

  // Checks.
  `CST_ASSERT_NOW(a_eof_is_last, out_valid_o && out_data_o.token_kind == KIND_EOF,
                  out_data_o.last_of_run)
  `CST_ASSERT_NOW(a_queue_bound, 1'b1, count_q <= CountBits'(FifoDepth))
  `CST_ASSERT_NEXT(a_eot_resets, in_accept && eot,
                   mode_q == MODE_IDLE && line_q == LineBits'(1) && col_q == ColumnBits'(1))
  `CST_ASSERT_NEXT(a_drain_only, !in_accept && out_accept,
                   count_q == $past(count_q) - CountBits'(1))

endmodule

`default_nettype wire
